// ===== hw/rtl/edt_pkg.sv =====
// ----------------------------------------------------------------------------
// Edit distance threshold package
// Shared types, register indexes and saturating helpers for the DP cell row.
// ----------------------------------------------------------------------------
package edt_pkg;

  localparam int unsigned LetterW  = 5;
  localparam int unsigned ValW     = 5;
  localparam int unsigned LettersW = 60;
  localparam int unsigned LenW     = 4;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 64;

  localparam logic [ValW-1:0] SatMax = 5'd31;

  localparam logic [1:0] REG_QUERY_LETTERS = 2'd0;
  localparam logic [1:0] REG_QUERY_LENGTH  = 2'd1;
  localparam logic [1:0] REG_THRESHOLD     = 2'd2;

  localparam logic [ValW-1:0] ThresholdReset = 5'd3;

  // One request travelling along the row of cells.
  typedef struct packed {
    logic                valid;
    logic                last;
    logic [LetterW-1:0]  letter;
    logic [ValW-1:0]     new_val;
    logic [ValW-1:0]     diag;
    logic [ValW-1:0]     score;
  } edt_link_t;

  function automatic logic [ValW-1:0] sat_inc(input logic [ValW-1:0] v);
    logic [ValW-1:0] r;
    r = (v == SatMax) ? SatMax : v + 5'd1;
    return r;
  endfunction

  function automatic logic [ValW-1:0] min3(input logic [ValW-1:0] a,
                                           input logic [ValW-1:0] b,
                                           input logic [ValW-1:0] c);
    logic [ValW-1:0] m;
    m = (a < b) ? a : b;
    m = (m < c) ? m : c;
    return m;
  endfunction

endpackage

// ===== hw/rtl/edt_head.sv =====
// ----------------------------------------------------------------------------
// Edit distance head column
// Counts candidate letters (column zero of the DP row) and launches each
// request into the cell row.
// ----------------------------------------------------------------------------
module edt_head (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic                      last_i,
  input  logic [edt_pkg::LetterW-1:0] letter_i,
  output edt_pkg::edt_link_t        link_o
);
  import edt_pkg::*;

  logic [ValW-1:0] seen_q, seen_d, seen_inc;
  edt_link_t       link_q, link_d;

  always_comb begin
    seen_inc       = sat_inc(seen_q);
    seen_d         = seen_q;
    link_d.valid   = valid_i;
    link_d.last    = last_i;
    link_d.letter  = letter_i;
    link_d.new_val = seen_inc;
    link_d.diag    = seen_q;
    link_d.score   = seen_inc;
    if (valid_i) begin
      seen_d = last_i ? '0 : seen_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      link_q <= '0;
    end else begin
      seen_q <= seen_d;
      link_q <= link_d;
    end
  end

  assign link_o = link_q;

endmodule

// ===== hw/rtl/edt_cell.sv =====
// ----------------------------------------------------------------------------
// Edit distance cell
// Holds one DP row entry, updates it for each passing letter and hands the
// new and old values to its right neighbor.
// ----------------------------------------------------------------------------
module edt_cell #(
  parameter int unsigned J = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  edt_pkg::edt_link_t          link_i,
  input  logic [edt_pkg::LetterW-1:0] query_letter_i,
  input  logic [edt_pkg::LenW-1:0]    qlen_i,
  output edt_pkg::edt_link_t          link_o
);
  import edt_pkg::*;

  localparam logic [LenW-1:0] JIdx   = LenW'(J);
  localparam logic [ValW-1:0] JReset = ValW'(J);

  logic [ValW-1:0] val_q, val_d, nv;
  edt_link_t       link_q, link_d;

  always_comb begin
    if (query_letter_i == link_i.letter) begin
      nv = link_i.diag;
    end else begin
      nv = sat_inc(min3(val_q, link_i.new_val, link_i.diag));
    end
    val_d          = val_q;
    link_d.valid   = link_i.valid;
    link_d.last    = link_i.last;
    link_d.letter  = link_i.letter;
    link_d.new_val = nv;
    link_d.diag    = val_q;
    link_d.score   = (qlen_i == JIdx) ? nv : link_i.score;
    if (link_i.valid) begin
      val_d = link_i.last ? JReset : nv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q  <= JReset;
      link_q <= '0;
    end else begin
      val_q  <= val_d;
      link_q <= link_d;
    end
  end

  assign link_o = link_q;

endmodule

// ===== hw/rtl/edit_distance_threshold_top.sv =====
// ----------------------------------------------------------------------------
// Edit distance threshold top level
// Levenshtein distance between a configured query word and streamed words.
// ----------------------------------------------------------------------------
// The user must write the query word, its length and the match threshold
// through the APB port only while the block is idle; it is not enforced.
// Candidate words arrive one letter per request on the input channel, the
// final letter marked by last_letter_i. Each letter enters a row of MAX_LEN
// cells, one per query letter, moving one cell per cycle, so letters are
// taken at one per cycle unless a last letter is stalled. A word's result
// leaves on the output channel once its last letter has passed the head, the
// cell row and the output register. Only one last letter may be in the row
// or waiting in the output register at a time, so a last letter is stalled
// while an earlier word's result is still under way or not yet taken; other
// letters are never stalled. A stalled result holds in the output register.
// Reset clears the row to its initial values, empties the row and the output
// register, and sets the threshold to three and the query to empty.
// ----------------------------------------------------------------------------
module edit_distance_threshold_top #(
  parameter int unsigned MAX_LEN = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [edt_pkg::AddrW-1:0]   paddr,
  input  logic [edt_pkg::DataW-1:0]   pwdata,
  output logic [edt_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [edt_pkg::LetterW-1:0] letter_i,
  input  logic                        last_letter_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [edt_pkg::ValW-1:0]    distance_o,
  output logic                        within_threshold_o
);
  import edt_pkg::*;

  localparam logic [LenW-1:0] MaxLenW = LenW'(MAX_LEN);

  logic [LettersW-1:0] query_letters_q;
  logic [LenW-1:0]     query_length_q;
  logic [ValW-1:0]     threshold_q;
  logic [LenW-1:0]     qlen;
  logic [1:0]          reg_idx;
  logic                cfg_wr;

  edt_link_t           links [MAX_LEN+1];
  logic [MAX_LEN:0]    last_in_row;
  logic                last_pend;
  logic                in_take;

  logic                out_valid_q, out_valid_d;
  logic [ValW-1:0]     distance_q;
  logic                within_q;
  edt_link_t           tail;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign cfg_wr  = psel && penable && pwrite && (paddr[2:0] == 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_letters_q <= '0;
      query_length_q  <= '0;
      threshold_q     <= ThresholdReset;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_QUERY_LETTERS: query_letters_q <= pwdata[LettersW-1:0];
        REG_QUERY_LENGTH:  query_length_q  <= pwdata[LenW-1:0];
        REG_THRESHOLD:     threshold_q     <= pwdata[ValW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_QUERY_LETTERS: prdata = {{(DataW-LettersW){1'b0}}, query_letters_q};
      REG_QUERY_LENGTH:  prdata = {{(DataW-LenW){1'b0}}, query_length_q};
      REG_THRESHOLD:     prdata = {{(DataW-ValW){1'b0}}, threshold_q};
      default:           prdata = '0;
    endcase
  end

  assign qlen = (query_length_q > MaxLenW) ? MaxLenW : query_length_q;

  always_comb begin
    for (int k = 0; k <= MAX_LEN; k++) begin
      last_in_row[k] = links[k].valid && links[k].last;
    end
  end

  assign last_pend  = |last_in_row;
  assign in_stall_o = last_letter_i && (last_pend || out_valid_q);
  assign in_take    = in_valid_i && !in_stall_o;

  edt_head u_head (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_take),
    .last_i   (last_letter_i),
    .letter_i (letter_i),
    .link_o   (links[0])
  );

  for (genvar j = 1; j <= MAX_LEN; j++) begin : g_cell
    edt_cell #(
      .J (j)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .link_i         (links[j-1]),
      .query_letter_i (query_letters_q[LetterW*(j-1) +: LetterW]),
      .qlen_i         (qlen),
      .link_o         (links[j])
    );
  end

  assign tail        = links[MAX_LEN];
  assign out_valid_d = (tail.valid && tail.last) || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tail.valid && tail.last) begin
      distance_q <= tail.score;
      within_q   <= (tail.score <= threshold_q);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign distance_o         = distance_q;
  assign within_threshold_o = within_q;

endmodule

// ===== hw/rtl/edt_checker.sv =====
// ----------------------------------------------------------------------------
// Edit distance threshold checker
// Port-level assertions on the top level, attached by a bind statement.
// ----------------------------------------------------------------------------
module edt_checker #(
  parameter int unsigned MAX_LEN = 12
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        pready,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        last_letter_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [edt_pkg::ValW-1:0]    distance_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(distance_o))
    else $error("Stalled result was dropped or changed.");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("APB port was not ready.");

  a_inner_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !last_letter_i |-> !in_stall_o)
    else $error("A letter that is not last was stalled.");

  a_last_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && last_letter_i && !in_stall_o |-> !out_valid_o)
    else $error("Last letter accepted while a result was waiting.");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && last_letter_i && !in_stall_o,
                                 MAX_LEN + 2))
    else $error("Result appeared without a last letter at the fixed latency.");

endmodule

bind edit_distance_threshold_top edt_checker #(
  .MAX_LEN (MAX_LEN)
) u_edt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .pready        (pready),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .last_letter_i (last_letter_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .distance_o    (distance_o)
);

// ===== test/edit_distance_threshold_top_test.sv =====
// ----------------------------------------------------------------------------
// Edit distance threshold testbench
// Streams candidate words into the block and checks each distance and flag.
// ----------------------------------------------------------------------------
// The bench keeps its own copy of the query registers and of the DP row and
// updates them for every accepted letter request. The block must return one
// result per word, in order. Directed words cover the reset settings, letter
// codes above z, query lengths beyond the row, and a query change in the middle
// of a word. Random words are then drawn around several query settings.
// Both channels idle at random, and one long output hold fills the block.
// ----------------------------------------------------------------------------
module edit_distance_threshold_top_test;
  import edt_pkg::*;

  localparam int MaxLen   = 12;
  localparam int TargetItems = 1750;
  localparam int StallLimit  = 4000;
  localparam int HoldCycles  = 300;

  typedef struct packed {
    logic [ValW-1:0] distance;
    logic            hit;
  } word_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrW-1:0]    paddr;
  logic [DataW-1:0]    pwdata;
  logic [DataW-1:0]    prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [LetterW-1:0]  letter_i;
  logic                last_letter_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [ValW-1:0]     distance_o;
  logic                within_threshold_o;

  logic [LettersW-1:0] query_cfg;
  logic [LenW-1:0]     qlen_cfg;
  logic [ValW-1:0]     thr_cfg;
  logic [ValW-1:0]     row_dist [0:MaxLen];
  logic [ValW-1:0]     seen_count;
  word_result_t        pending_results [$];
  logic [LetterW-1:0]  word_buf [$];

  int errors;
  int items_sent;
  int words_sent;
  int results_checked;
  int settings_used;
  int hold_req;
  bit idle_off;
  bit out_taken;

  edit_distance_threshold_top #(
    .MAX_LEN(MaxLen)
  ) DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .letter_i           (letter_i),
    .last_letter_i      (last_letter_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .distance_o         (distance_o),
    .within_threshold_o (within_threshold_o)
  );

  initial begin
    clk_i = 1'b0;
    forever begin
      #4 clk_i = ~clk_i;
    end
  end

  function automatic logic [ValW-1:0] sat_bump(input logic [ValW-1:0] v);
    return (v == SatMax) ? v : v + 5'd1;
  endfunction

  function automatic int draw_gap();
    return idle_off ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic logic [LetterW-1:0] pick_letter(input bit narrow);
    if (narrow) begin
      return LetterW'($urandom_range(0, 3));
    end
    if ($urandom_range(0, 7) == 0) begin
      return LetterW'($urandom_range(26, 31));
    end
    return LetterW'($urandom_range(0, 25));
  endfunction

  task automatic clear_row();
    for (int j = 0; j <= MaxLen; j++) begin
      row_dist[j] = ValW'(j);
    end
    seen_count = '0;
  endtask

  // Advances the DP row by one candidate letter; a last letter yields a result.
  task automatic apply_letter(input logic [LetterW-1:0] l, input logic last);
    logic [ValW-1:0] nxt [0:MaxLen];
    logic [ValW-1:0] m;
    int              eff;
    word_result_t    r;
    seen_count = sat_bump(seen_count);
    nxt[0] = seen_count;
    for (int j = 1; j <= MaxLen; j++) begin
      if (query_cfg[5*(j-1) +: 5] == l) begin
        nxt[j] = row_dist[j-1];
      end else begin
        m = (row_dist[j] < nxt[j-1]) ? row_dist[j] : nxt[j-1];
        if (row_dist[j-1] < m) begin
          m = row_dist[j-1];
        end
        nxt[j] = sat_bump(m);
      end
    end
    row_dist = nxt;
    if (last) begin
      eff = (qlen_cfg > MaxLen) ? MaxLen : int'(qlen_cfg);
      r.distance = row_dist[eff];
      r.hit = (r.distance <= thr_cfg);
      pending_results.insert(pending_results.size(), r);
      clear_row();
    end
  endtask

  task automatic send_letter(input logic [LetterW-1:0] l, input logic last);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    letter_i      <= l;
    last_letter_i <= last;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    apply_letter(l, last);
    items_sent++;
    if (last) begin
      words_sent++;
    end
    @(negedge clk_i);
  endtask

  task automatic send_word();
    for (int i = 0; i < word_buf.size(); i++) begin
      send_letter(word_buf[i], i == word_buf.size() - 1);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() > 0) begin
      @(negedge clk_i);
    end
    repeat (MaxLen + 4) @(negedge clk_i);
  endtask

  // Writes one register with junk above its width, then reads it back.
  task automatic cfg_write(input logic [1:0] idx, input logic [DataW-1:0] val);
    logic [DataW-1:0] data;
    logic [DataW-1:0] mask;
    data = {$urandom, $urandom};
    case (idx)
      REG_QUERY_LETTERS: begin
        mask = {{(DataW-LettersW){1'b0}}, {LettersW{1'b1}}};
        query_cfg = val[LettersW-1:0];
      end
      REG_QUERY_LENGTH: begin
        mask = {{(DataW-LenW){1'b0}}, {LenW{1'b1}}};
        qlen_cfg = val[LenW-1:0];
      end
      default: begin
        mask = {{(DataW-ValW){1'b0}}, {ValW{1'b1}}};
        thr_cfg = val[ValW-1:0];
      end
    endcase
    data = (data & ~mask) | (val & mask);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    if ((prdata & mask) !== (val & mask)) begin
      errors++;
      $display("%0t: register %0d read back: expected %h, actual %h",
               $time, idx, val & mask, prdata & mask);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_query(input logic [LettersW-1:0] letters, input int len,
                           input int thr);
    cfg_write(REG_QUERY_LETTERS, DataW'(letters));
    cfg_write(REG_QUERY_LENGTH, DataW'(len));
    cfg_write(REG_THRESHOLD, DataW'(thr));
    settings_used++;
  endtask

  // Most words are the query with a few edits, so that distances stay small.
  task automatic build_word();
    int kind;
    int len;
    int pos;
    bit narrow;
    word_buf.delete();
    kind = $urandom_range(0, 9);
    narrow = ($urandom_range(0, 2) == 0);
    if (kind <= 5) begin
      len = (qlen_cfg > MaxLen) ? MaxLen : int'(qlen_cfg);
      for (int j = 0; j < len; j++) begin
        word_buf.insert(word_buf.size(), query_cfg[5*j +: 5]);
      end
      repeat ($urandom_range(0, 3)) begin
        pos = $urandom_range(0, word_buf.size());
        case ($urandom_range(0, 2))
          0: begin
            if (pos < word_buf.size()) begin
              word_buf[pos] = pick_letter(narrow);
            end
          end
          1: word_buf.insert(pos, pick_letter(narrow));
          default: begin
            if (pos < word_buf.size() && word_buf.size() > 1) begin
              word_buf.delete(pos);
            end
          end
        endcase
      end
    end else begin
      len = (kind == 9 && $urandom_range(0, 3) == 0) ? $urandom_range(28, 40)
                                                      : $urandom_range(1, 14);
      repeat (len) word_buf.insert(word_buf.size(), pick_letter(narrow));
    end
    if (word_buf.size() == 0) begin
      word_buf.insert(0, pick_letter(narrow));
    end
  endtask

  task automatic test_reset_defaults();
    word_buf = '{5'd0};
    send_word();
    word_buf = '{5'd25, 5'd25, 5'd25, 5'd25};
    send_word();
  endtask

  task automatic test_high_codes();
    wait_idle();
    set_query({40'd0, 5'd25, 5'd0, 5'd26, 5'd31}, 4, 0);
    word_buf = '{5'd31, 5'd26, 5'd0, 5'd25};
    send_word();
    word_buf = '{5'd31, 5'd26, 5'd25};
    send_word();
  endtask

  task automatic test_length_clamp();
    wait_idle();
    set_query({LettersW{1'b1}}, 15, 31);
    word_buf = '{5'd31};
    send_word();
    wait_idle();
    cfg_write(REG_QUERY_LENGTH, DataW'(0));
    word_buf = '{5'd0, 5'd31};
    send_word();
  endtask

  task automatic test_mid_word_change();
    wait_idle();
    set_query({45'd0, 5'd19, 5'd0, 5'd2}, 3, 1);
    send_letter(5'd2, 1'b0);
    send_letter(5'd0, 1'b0);
    wait_idle();
    set_query({45'd0, 5'd19, 5'd14, 5'd3}, 3, 1);
    send_letter(5'd19, 1'b1);
  endtask

  task automatic test_output_hold();
    wait_idle();
    set_query({45'd0, 5'd7, 5'd4, 5'd1}, 3, 2);
    idle_off = 1'b1;
    hold_req = HoldCycles;
    repeat (40) begin
      word_buf.delete();
      repeat ($urandom_range(1, 2)) word_buf.insert(word_buf.size(), pick_letter(1'b0));
      send_word();
    end
    idle_off = 1'b0;
  endtask

  task automatic test_random_words();
    logic [LettersW-1:0] letters;
    int                  len;
    int                  thr;
    int                  phase_end;
    int                  p;
    bit                  narrow;
    p = 0;
    while (items_sent < TargetItems) begin
      wait_idle();
      narrow = ($urandom_range(0, 1) == 0);
      case ($urandom_range(0, 5))
        0: letters = LettersW'({$urandom, $urandom});
        1: letters = {LettersW{1'b1}};
        2: letters = '0;
        default: begin
          for (int j = 0; j < MaxLen; j++) begin
            letters[5*j +: 5] = pick_letter(narrow);
          end
        end
      endcase
      len = $urandom_range(0, 15);
      if (p % 5 == 0) begin
        len = MaxLen;
      end else if (p % 7 == 3) begin
        len = 0;
      end
      thr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 6);
      if (p % 4 == 1) begin
        thr = 0;
      end else if (p % 4 == 2) begin
        thr = 31;
      end
      set_query(letters, len, thr);
      phase_end = items_sent + $urandom_range(60, 200);
      while (items_sent < phase_end && items_sent < TargetItems) begin
        idle_off = ($urandom_range(0, 7) == 0);
        build_word();
        send_word();
      end
      idle_off = 1'b0;
      if (items_sent < TargetItems && $urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) send_letter(pick_letter(narrow), 1'b0);
      end
      p++;
    end
  endtask

  // Result side: draws a stall for each result and honors a long hold request.
  initial begin
    int wait_left;
    out_stall_i = 1'b0;
    wait_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        wait_left = hold_req;
        hold_req = 0;
      end else if (out_taken) begin
        wait_left = draw_gap();
      end
      out_taken = 1'b0;
      out_stall_i <= (wait_left > 0);
      if (wait_left > 0) begin
        wait_left--;
      end
    end
  end

  initial begin
    word_result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        out_taken = 1'b1;
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual distance %0d flag %0b",
                   $time, distance_o, within_threshold_o);
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (distance_o !== want.distance) begin
            errors++;
            $display("%0t: distance mismatch: expected %0d, actual %0d",
                     $time, want.distance, distance_o);
          end
          if (within_threshold_o !== want.hit) begin
            errors++;
            $display("%0t: threshold flag mismatch: expected %0b, actual %0b",
                     $time, want.hit, within_threshold_o);
          end
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= StallLimit) begin
        $display("%0t: no request moved for %0d cycles", $time, StallLimit);
        $display("edit_distance_threshold_top_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid_i    = 1'b0;
    letter_i      = '0;
    last_letter_i = 1'b0;
    errors          = 0;
    items_sent      = 0;
    words_sent      = 0;
    results_checked = 0;
    settings_used   = 1;
    hold_req        = 0;
    idle_off        = 1'b0;
    out_taken       = 1'b0;
    query_cfg = '0;
    qlen_cfg  = '0;
    thr_cfg   = ThresholdReset;
    clear_row();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_high_codes();
    test_length_clamp();
    test_mid_word_change();
    test_output_hold();
    test_random_words();

    wait_idle();
    repeat (4) @(negedge clk_i);
    $display("Sent %0d letters in %0d words over %0d query settings.",
             items_sent, words_sent, settings_used);
    $display("Checked %0d distances, with random idling and a %0d-cycle output hold.",
             results_checked, HoldCycles);
    if (errors == 0) begin
      $display("edit_distance_threshold_top_test OK");
    end else begin
      $display("edit_distance_threshold_top_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/edt_pkg.sv
hw/rtl/edt_head.sv
hw/rtl/edt_cell.sv
hw/rtl/edit_distance_threshold_top.sv
hw/rtl/edt_checker.sv
test/edit_distance_threshold_top_test.sv
